/* src/e2d_pkg.sv */
`timescale 1ns / 1ps
// Package for the Euler-angle to direction cosine matrix block.
// Holds fixed-point constants, the CORDIC arctangent table and shared helpers.
package e2d_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int TabLen = 24;
  localparam int AngW = 16;
  localparam int EntW = 16;
  localparam int AccW = 36;

  localparam logic signed [AccW-1:0] Q30Pi = 36'sd3373259426;
  localparam logic signed [AccW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [AccW-1:0] Q30TwoPi = 36'sd6746518852;
  localparam logic signed [AccW-1:0] Q30Gain = 36'sd652032874;
  localparam logic signed [EntW-1:0] OneQ14 = 16'sd16384;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [EntW-1:0] ent_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    ang_t yaw_angle;
    ang_t pitch_angle;
    ang_t roll_angle;
  } att_t;

  typedef struct packed {
    ent_t entry_00;
    ent_t entry_01;
    ent_t entry_02;
    ent_t entry_10;
    ent_t entry_11;
    ent_t entry_12;
    ent_t entry_20;
    ent_t entry_21;
    ent_t entry_22;
  } dcm_t;

  function automatic acc_t atan_tab(input int i);
    acc_t t;
    case (i)
      0: t = 36'sh03243F6A8;
      1: t = 36'sh01DAC6705;
      2: t = 36'sh00FADBAFC;
      3: t = 36'sh007F56EA6;
      4: t = 36'sh003FEAB76;
      5: t = 36'sh001FFD55B;
      6: t = 36'sh000FFFAAA;
      7: t = 36'sh0007FFF55;
      8: t = 36'sh0003FFFEA;
      9: t = 36'sh0001FFFFD;
      10: t = 36'sh0000FFFFF;
      11: t = 36'sh00007FFFF;
      12: t = 36'sh00003FFFF;
      13: t = 36'sh00001FFFF;
      14: t = 36'sh00000FFFF;
      15: t = 36'sh000007FFF;
      16: t = 36'sh000003FFF;
      17: t = 36'sh000001FFF;
      18: t = 36'sh000000FFF;
      19: t = 36'sh0000007FF;
      20: t = 36'sh0000003FF;
      21: t = 36'sh0000001FF;
      22: t = 36'sh0000000FF;
      default: t = 36'sh00000007F;
    endcase
    return t;
  endfunction

  // Saturate a wide signed value to plus or minus one in Q14.
  function automatic ent_t sat_one(input logic signed [63:0] v);
    ent_t r;
    if (v > 64'sd16384) r = OneQ14;
    else if (v < -64'sd16384) r = -OneQ14;
    else r = ent_t'(v);
    return r;
  endfunction

endpackage

/* src/e2d_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for attitude input and matrix output.
// Depends on e2d_pkg for payload types.
interface e2d_att_if;
  logic valid;
  logic ready;
  e2d_pkg::att_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface e2d_dcm_if;
  logic valid;
  logic ready;
  e2d_pkg::dcm_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/euler_to_dcm_declination.sv */
`timescale 1ns / 1ps
// Euler angles (yaw, pitch, roll) to a direction cosine matrix, premultiplied
// by a z rotation through the declination register. Depends on e2d_pkg,
// e2d_if, e2d_cordic and e2d_matrix.
//
// The att channel carries one transaction per attitude sample; the dcm
// channel carries one transaction per sample with the nine Q14 entries.
// The pipeline advances in every cycle in which its last stage is empty or
// the receiver takes the result, so one transaction enters per cycle and
// results leave in input order. Each sample passes through the CORDIC stage
// chain and then the four matrix stages.
// When the receiver stalls the whole pipeline holds; nothing is dropped or
// repeated, and att.ready falls until the result is taken.
// The declination register is written through cfg_we/cfg_data and should only
// change while the pipeline is empty. Synchronous reset clears all valid bits
// and sets the declination to zero; data registers are not reset.
module euler_to_dcm_declination #(
  parameter int CORDIC_STAGES = e2d_pkg::CordicStagesDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_data,
  e2d_att_if.sink                  att,
  e2d_dcm_if.source                dcm
);
  import e2d_pkg::*;

  localparam int Lat = CORDIC_STAGES + 6;

  ang_t declination_angle;
  logic [Lat-1:0] vld;
  logic en;
  ent_t sps, cps, sth, cth, sph, cph, sd, cd;

  always_ff @(posedge clk) begin
    if (rst) declination_angle <= '0;
    else if (cfg_we) declination_angle <= ang_t'(cfg_data);
  end

  // Whole-pipeline enable: advance unless a finished result is stalled.
  assign en = !vld[Lat-1] || dcm.ready;
  assign att.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], att.valid};
  end

  e2d_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .ang(att.data.yaw_angle), .sin_q14(sps), .cos_q14(cps));
  e2d_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .ang(att.data.pitch_angle), .sin_q14(sth), .cos_q14(cth));
  e2d_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .ang(att.data.roll_angle), .sin_q14(sph), .cos_q14(cph));
  e2d_cordic #(.STAGES(CORDIC_STAGES)) u_decl (
    .clk(clk), .en(en), .ang(declination_angle), .sin_q14(sd), .cos_q14(cd));

  e2d_matrix u_matrix (
    .clk(clk), .en(en), .sps(sps), .cps(cps), .sth(sth), .cth(cth),
    .sph(sph), .cph(cph), .sd(sd), .cd(cd), .dcm(dcm.data));

  assign dcm.valid = vld[Lat-1];
endmodule

/* src/e2d_cordic.sv */
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one angle per enabled cycle in, Q14 sine and cosine out.
// Depends on e2d_pkg. Angles pass through an input register, the rotation stages and an output register.
module e2d_cordic #(
  parameter int STAGES = e2d_pkg::CordicStagesDefault
) (
  input  logic            clk,
  input  logic            en,
  input  e2d_pkg::ang_t   ang,
  output e2d_pkg::ent_t   sin_q14,
  output e2d_pkg::ent_t   cos_q14
);
  import e2d_pkg::*;

  acc_t x [STAGES+1];
  acc_t y [STAGES+1];
  acc_t z [STAGES+1];
  logic neg [STAGES+1];
  acc_t a_w, a_r;
  logic neg_w;

  // Range reduction into [-pi/2, pi/2].
  always_comb begin
    a_w = acc_t'(ang) <<< 18;
    neg_w = 1'b0;
    if (a_w > Q30Pi) a_w = a_w - Q30TwoPi;
    if (a_w < -Q30Pi) a_w = a_w + Q30TwoPi;
    if (a_w > Q30HalfPi) begin
      a_w = Q30Pi - a_w;
      neg_w = 1'b1;
    end else if (a_w < -Q30HalfPi) begin
      a_w = -Q30Pi - a_w;
      neg_w = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= Q30Gain;
      y[0] <= '0;
      z[0] <= a_w;
      neg[0] <= neg_w;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][AccW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_tab(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_tab(i);
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  assign a_r = neg[STAGES] ? -x[STAGES] : x[STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q14 <= sat_one(64'(y[STAGES] + 36'sd32768) >>> 16);
      cos_q14 <= sat_one(64'(a_r + 36'sd32768) >>> 16);
    end
  end
endmodule

/* src/e2d_matrix.sv */
`timescale 1ns / 1ps
// Four-stage matrix pipeline: ZYX direction cosine matrix, then the z rotation.
// Depends on e2d_pkg; inputs are Q14 sines and cosines.
module e2d_matrix (
  input  logic          clk,
  input  logic          en,
  input  e2d_pkg::ent_t sps, cps, sth, cth, sph, cph, sd, cd,
  output e2d_pkg::dcm_t dcm
);
  import e2d_pkg::*;

  typedef logic signed [31:0] p2_t;
  typedef logic signed [47:0] p3_t;

  // Stage 1: pairwise products (Q28).
  p2_t sth_cps, sth_sps, cph_sps, sph_sps, cph_cps, sph_cps, cth_cps, cth_sps;
  p2_t sph_cth, cph_cth;
  ent_t s1_sph, s1_cph, s1_sth, s1_sd, s1_cd;
  always_ff @(posedge clk) begin
    if (en) begin
      sth_cps <= p2_t'(sth) * p2_t'(cps); sth_sps <= p2_t'(sth) * p2_t'(sps);
      cph_sps <= p2_t'(cph) * p2_t'(sps); sph_sps <= p2_t'(sph) * p2_t'(sps);
      cph_cps <= p2_t'(cph) * p2_t'(cps); sph_cps <= p2_t'(sph) * p2_t'(cps);
      cth_cps <= p2_t'(cth) * p2_t'(cps); cth_sps <= p2_t'(cth) * p2_t'(sps);
      sph_cth <= p2_t'(sph) * p2_t'(cth); cph_cth <= p2_t'(cph) * p2_t'(cth);
      s1_sph <= sph; s1_cph <= cph; s1_sth <= sth; s1_sd <= sd; s1_cd <= cd;
    end
  end

  // Stage 2: Q42 sums, rounded and saturated to Q14.
  function automatic ent_t rq42(input p3_t v);
    return sat_one(64'(v + 48'sd134217728) >>> 28);
  endfunction
  function automatic p3_t w14(input p2_t v);
    return p3_t'(v) <<< 14;
  endfunction

  ent_t b [9];
  ent_t s2_sd, s2_cd;
  always_ff @(posedge clk) begin
    if (en) begin
      b[0] <= rq42(w14(cth_cps));
      b[1] <= rq42(p3_t'(s1_sph) * p3_t'(sth_cps) - w14(cph_sps));
      b[2] <= rq42(p3_t'(s1_cph) * p3_t'(sth_cps) + w14(sph_sps));
      b[3] <= rq42(w14(cth_sps));
      b[4] <= rq42(p3_t'(s1_sph) * p3_t'(sth_sps) + w14(cph_cps));
      b[5] <= rq42(p3_t'(s1_cph) * p3_t'(sth_sps) - w14(sph_cps));
      b[6] <= rq42(-(p3_t'(s1_sth) <<< 28));
      b[7] <= rq42(w14(sph_cth));
      b[8] <= rq42(w14(cph_cth));
      s2_sd <= s1_sd; s2_cd <= s1_cd;
    end
  end

  // Stage 3: declination products (Q28).
  p2_t cb0 [3], sb1 [3], sb0 [3], cb1 [3];
  ent_t b2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        cb0[j] <= p2_t'(s2_cd) * p2_t'(b[j]);
        sb1[j] <= p2_t'(s2_sd) * p2_t'(b[3+j]);
        sb0[j] <= p2_t'(s2_sd) * p2_t'(b[j]);
        cb1[j] <= p2_t'(s2_cd) * p2_t'(b[3+j]);
        b2[j] <= b[6+j];
      end
    end
  end

  // Stage 4: sums, round to Q14.
  function automatic ent_t rq28(input logic signed [32:0] v);
    return sat_one(64'(v + 33'sd8192) >>> 14);
  endfunction
  always_ff @(posedge clk) begin
    if (en) begin
      dcm.entry_00 <= rq28(33'(cb0[0]) - 33'(sb1[0]));
      dcm.entry_01 <= rq28(33'(cb0[1]) - 33'(sb1[1]));
      dcm.entry_02 <= rq28(33'(cb0[2]) - 33'(sb1[2]));
      dcm.entry_10 <= rq28(33'(sb0[0]) + 33'(cb1[0]));
      dcm.entry_11 <= rq28(33'(sb0[1]) + 33'(cb1[1]));
      dcm.entry_12 <= rq28(33'(sb0[2]) + 33'(cb1[2]));
      dcm.entry_20 <= b2[0];
      dcm.entry_21 <= b2[1];
      dcm.entry_22 <= b2[2];
    end
  end
endmodule

/* src/e2d_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the attitude to matrix block, bound to the top level.
// Depends on e2d_pkg for the Q14 range.
module e2d_checker (
  input logic clk,
  input logic rst,
  input logic att_valid,
  input logic att_ready,
  input logic dcm_valid,
  input logic dcm_ready,
  input e2d_pkg::dcm_t dcm_data
);
  import e2d_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dcm_valid && !dcm_ready |=> dcm_valid && $stable(dcm_data))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !dcm_valid |-> att_ready)
    else $error("input blocked with empty output");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    dcm_valid && !dcm_ready |-> !att_ready)
    else $error("input taken while output stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    dcm_valid |-> dcm_data.entry_22 <= OneQ14 && dcm_data.entry_22 >= -OneQ14)
    else $error("entry out of range");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !dcm_valid)
    else $error("result valid after reset");
endmodule

bind euler_to_dcm_declination e2d_checker u_chk (
  .clk(clk), .rst(rst), .att_valid(att.valid), .att_ready(att.ready),
  .dcm_valid(dcm.valid), .dcm_ready(dcm.ready), .dcm_data(dcm.data));
